// ===== hw/rtl/slesc_pkg.sv =====
package slesc_pkg;

  typedef enum logic [1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_SET_NOW    = 2'd1,
    CMD_TICK       = 2'd2
  } cmd_t;

  localparam logic [2:0] REG_PULSE_MIN      = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX      = 3'd1;
  localparam logic [2:0] REG_PULSE_CENTER   = 3'd2;
  localparam logic [2:0] REG_STEP_SIZE      = 3'd3;
  localparam logic [2:0] REG_SNAP_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd5;

  localparam logic [14:0] PULSE_MIN_RST      = 15'd1100;
  localparam logic [14:0] PULSE_MAX_RST      = 15'd1900;
  localparam logic [14:0] PULSE_CENTER_RST   = 15'd1500;
  localparam logic [9:0]  STEP_SIZE_RST      = 10'd10;
  localparam logic [12:0] SNAP_THRESHOLD_RST = 13'd50;
  localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd300;

  localparam logic signed [12:0] MAG_LIMIT = 13'sd1000;

  // floor(p/2000): offset by 2000*16384 to stay positive, drop 4 bits (2000 = 16*125),
  // then divide by 125 as a multiply by ceil(2^29/125) and a shift of 29.
  localparam logic signed [26:0] DIV_OFFSET = 27'sd32768000;
  localparam logic [22:0]        RECIP_125  = 23'd4294968;
  localparam int                 RECIP_SHIFT = 29;
  localparam logic signed [17:0] QUOT_BIAS  = 18'sd16384;

  function automatic logic signed [10:0] clamp_mag(input logic signed [12:0] m);
    logic signed [12:0] r;
    begin
      if (m > MAG_LIMIT) begin
        r = MAG_LIMIT;
      end else if (m < -MAG_LIMIT) begin
        r = -MAG_LIMIT;
      end else begin
        r = m;
      end
      return r[10:0];
    end
  endfunction

endpackage

// ===== hw/rtl/slew_limited_esc_pulse_channel_unit.sv =====
// Slew-limited thruster pulse channel.
// Input channel (in_valid/in_stall): cmd and target_magnitude. cmd 0 stores a
// target, cmd 1 sets the magnitude at once, cmd 2 is a tick that runs the
// watchdog and moves the magnitude a step toward the target or snaps onto it.
// Output channel (out_valid/out_stall): one item per input item, in order,
// carrying pulse_width, magnitude_now and timed_out.
// Config port: cfg_write_en, cfg_index, cfg_data; write only while idle.
// Items pass v1, v2, v3 and the output register to out_valid. Throughput: one
// item per cycle while out_stall is low. Magnitude state updates in the accept
// cycle; the pulse mapping runs in three stages behind it (product, reciprocal
// multiply, offset and clamp). A stalled output holds its item; stall backs up
// the stages and reaches in_stall only when every stage is full.
// Reset: synchronous, clears the pipeline, magnitudes, watchdog, and loads the
// default config; pulse width starts at 1500 us.
module slew_limited_esc_pulse_channel_unit
  import slesc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [12:0] target_magnitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        pulse_width,
  output logic signed [10:0] magnitude_now,
  output logic               timed_out,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [14:0] pulse_min;
  logic [14:0] pulse_max;
  logic [14:0] pulse_center;
  logic [9:0]  step_size;
  logic [12:0] snap_threshold;
  logic [15:0] timeout_ticks;

  logic signed [12:0] target;
  logic signed [12:0] current;
  logic [15:0]        idle_ticks;
  logic               armed;
  logic [14:0]        pulse_value;

  logic signed [12:0] target_next;
  logic signed [12:0] current_next;
  logic [15:0]        idle_ticks_next;
  logic               armed_next;
  logic               fire;
  logic               recompute;

  logic [15:0]        idle_inc;
  logic signed [12:0] tgt_eff;
  logic signed [13:0] gap;
  logic [13:0]        agap;
  logic signed [13:0] cur_up;
  logic signed [13:0] cur_dn;

  logic               v1, rc1, to1;
  logic signed [10:0] mag1;
  logic               v2, rc2, to2;
  logic signed [10:0] mag2;
  logic signed [26:0] prod2;
  logic               v3, rc3, to3;
  logic signed [10:0] mag3;
  logic [44:0]        qp3;

  logic rdy1, rdy2, rdy3, rdy4, accept;

  logic signed [15:0] span;
  logic signed [26:0] shifted;
  logic [21:0]        div_in;
  logic [15:0]        quot;
  logic signed [17:0] p_raw;
  logic [14:0]        p_map;
  logic [14:0]        pulse_sel;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min      <= PULSE_MIN_RST;
      pulse_max      <= PULSE_MAX_RST;
      pulse_center   <= PULSE_CENTER_RST;
      step_size      <= STEP_SIZE_RST;
      snap_threshold <= SNAP_THRESHOLD_RST;
      timeout_ticks  <= TIMEOUT_TICKS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PULSE_MIN:      pulse_min      <= cfg_data[14:0];
        REG_PULSE_MAX:      pulse_max      <= cfg_data[14:0];
        REG_PULSE_CENTER:   pulse_center   <= cfg_data[14:0];
        REG_STEP_SIZE:      step_size      <= cfg_data[9:0];
        REG_SNAP_THRESHOLD: snap_threshold <= cfg_data[12:0];
        REG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-item state update
  always_comb begin
    target_next     = target;
    current_next    = current;
    idle_ticks_next = idle_ticks;
    armed_next      = armed;
    fire            = 1'b0;
    recompute       = 1'b0;
    idle_inc        = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
    if (cmd == CMD_TICK && armed && idle_inc > timeout_ticks) begin
      fire = 1'b1;
    end
    tgt_eff = fire ? 13'sd0 : target;
    gap     = {tgt_eff[12], tgt_eff} - {current[12], current};
    agap    = gap[13] ? 14'(-gap) : 14'(gap);
    cur_up  = {current[12], current} + $signed({4'b0, step_size});
    cur_dn  = {current[12], current} - $signed({4'b0, step_size});
    unique case (cmd)
      CMD_SET_TARGET: begin
        target_next     = target_magnitude;
        idle_ticks_next = '0;
        armed_next      = 1'b1;
      end
      CMD_SET_NOW: begin
        current_next    = target_magnitude;
        idle_ticks_next = '0;
        armed_next      = 1'b1;
        recompute       = 1'b1;
      end
      CMD_TICK: begin
        if (armed) begin
          idle_ticks_next = fire ? 16'd0 : idle_inc;
        end
        target_next = tgt_eff;
        if (gap != 14'sd0) begin
          recompute = 1'b1;
          if (agap > {1'b0, snap_threshold}) begin
            if (agap <= {4'b0, step_size}) begin
              current_next = tgt_eff;
            end else if (!gap[13]) begin
              current_next = cur_up[12:0];
            end else begin
              current_next = cur_dn[12:0];
            end
          end else begin
            current_next = tgt_eff;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target     <= '0;
      current    <= '0;
      idle_ticks <= '0;
      armed      <= 1'b0;
    end else if (accept) begin
      target     <= target_next;
      current    <= current_next;
      idle_ticks <= idle_ticks_next;
      armed      <= armed_next;
    end
  end

  // pulse mapping pipeline
  assign span    = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
  assign shifted = prod2 + DIV_OFFSET;
  assign div_in  = shifted[25:4];
  assign quot    = qp3[44:RECIP_SHIFT];
  assign p_raw   = $signed({2'b0, quot}) - QUOT_BIAS + $signed({3'b0, pulse_center});

  always_comb begin
    if (p_raw > $signed({3'b0, pulse_max})) begin
      p_map = pulse_max;
    end else if (p_raw < $signed({3'b0, pulse_min})) begin
      p_map = pulse_min;
    end else begin
      p_map = p_raw[14:0];
    end
    pulse_sel = rc3 ? p_map : pulse_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      out_valid   <= 1'b0;
      pulse_value <= PULSE_CENTER_RST;
    end else begin
      if (rdy1) begin
        v1 <= accept;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        out_valid <= v3;
        if (v3) begin
          pulse_value <= pulse_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rc1  <= recompute;
      to1  <= fire;
      mag1 <= clamp_mag(current_next);
    end
    if (rdy2) begin
      rc2   <= rc1;
      to2   <= to1;
      mag2  <= mag1;
      prod2 <= 27'(mag1) * 27'(span);
    end
    if (rdy3) begin
      rc3  <= rc2;
      to3  <= to2;
      mag3 <= mag2;
      qp3  <= {23'b0, div_in} * {22'b0, RECIP_125};
    end
    if (rdy4 && v3) begin
      pulse_width   <= pulse_sel;
      magnitude_now <= mag3;
      timed_out     <= to3;
    end
  end

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (magnitude_now <= 11'sd1000 && magnitude_now >= -11'sd1000))
    else $error("magnitude_now out of range");

  a_arm_on_set: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_SET_TARGET || cmd == CMD_SET_NOW)) |=>
      (armed && idle_ticks == 16'd0))
    else $error("set command did not arm watchdog");

  a_idle_unarmed: assert property (@(posedge clk) disable iff (rst)
    !armed |-> idle_ticks == 16'd0)
    else $error("idle count moved while unarmed");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !v1 && !v2 && !v3) |-> !in_stall)
    else $error("input stalled with empty pipeline");

  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && fire) |=> (target == 13'sd0 && idle_ticks == 16'd0))
    else $error("watchdog fire did not clear target");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import slesc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 7;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [12:0] mag;
  } chan_item_t;

  typedef struct {
    int pw;
    int mag;
    bit fired;
  } chan_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = CMD_TICK;
  logic signed [12:0] target_magnitude = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [14:0]        pulse_width;
  logic signed [10:0] magnitude_now;
  logic               timed_out;
  logic               cfg_write_en = 1'b0;
  logic [2:0]         cfg_index = REG_PULSE_MIN;
  logic [15:0]        cfg_data = '0;

  slew_limited_esc_pulse_channel_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .target_magnitude (target_magnitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pulse_width      (pulse_width),
    .magnitude_now    (magnitude_now),
    .timed_out        (timed_out),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // channel model state and registers
  int cfg_pmin = PULSE_MIN_RST;
  int cfg_pmax = PULSE_MAX_RST;
  int cfg_center = PULSE_CENTER_RST;
  int cfg_step = STEP_SIZE_RST;
  int cfg_snap = SNAP_THRESHOLD_RST;
  int cfg_timeout = TIMEOUT_TICKS_RST;
  int aim_mag = 0;
  int now_mag = 0;
  int held_pulse = PULSE_CENTER_RST;
  int idle_count = 0;
  bit armed = 1'b0;

  chan_item_t   pending_items[$];
  chan_result_t expected_pulses[$];
  chan_item_t   next_item;
  int  mismatches = 0;
  int  tx_idle_pct = 13;
  int  rx_idle_pct = 63;
  bit  tx_hold = 1'b0;
  bit  rx_hold = 1'b0;
  bit  in_took = 1'b0;

  function automatic int limit_mag(int m);
    if (m > 1000) return 1000;
    if (m < -1000) return -1000;
    return m;
  endfunction

  function automatic int map_pulse(int m);
    longint prod, q, p;
    prod = longint'(limit_mag(m)) * longint'(cfg_pmax - cfg_pmin);
    q = prod / 2000;
    if (prod % 2000 != 0 && prod < 0) q = q - 1;
    p = q + cfg_center;
    if (p > cfg_pmax) p = cfg_pmax;
    else if (p < cfg_pmin) p = cfg_pmin;
    return int'(p) & 'h7FFF;
  endfunction

  function automatic chan_result_t advance_channel(logic [1:0] op, logic signed [12:0] mag);
    chan_result_t r;
    int gap, agap;
    r.fired = 1'b0;
    case (op)
      CMD_SET_TARGET: begin
        aim_mag = mag;
        idle_count = 0;
        armed = 1'b1;
      end
      CMD_SET_NOW: begin
        now_mag = mag;
        idle_count = 0;
        armed = 1'b1;
        held_pulse = map_pulse(now_mag);
      end
      CMD_TICK: begin
        if (armed) begin
          if (idle_count < 65535) idle_count++;
          if (idle_count > cfg_timeout) begin
            aim_mag = 0;
            idle_count = 0;
            r.fired = 1'b1;
          end
        end
        gap = aim_mag - now_mag;
        if (gap != 0) begin
          agap = (gap < 0) ? -gap : gap;
          if (agap > cfg_snap) begin
            if (agap <= cfg_step) now_mag = aim_mag;
            else if (gap > 0) now_mag += cfg_step;
            else now_mag -= cfg_step;
          end else begin
            now_mag = aim_mag;
          end
          held_pulse = map_pulse(now_mag);
        end
      end
      default: ;
    endcase
    r.pw = held_pulse;
    r.mag = limit_mag(now_mag);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_items.size() > 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        cmd <= next_item.op;
        target_magnitude <= next_item.mag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    chan_result_t want;
    in_took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_pulses.push_back(advance_channel(cmd, target_magnitude));
      if (out_valid && !out_stall) begin
        if (expected_pulses.size() == 0) begin
          flag_mismatch("item with none expected", pulse_width, -1);
        end else begin
          want = expected_pulses.pop_front();
          if (int'(pulse_width) != want.pw)
            flag_mismatch("pulse_width", pulse_width, want.pw);
          if (int'(magnitude_now) != want.mag)
            flag_mismatch("magnitude_now", magnitude_now, want.mag);
          if (timed_out != want.fired)
            flag_mismatch("timed_out", timed_out, want.fired);
        end
      end
    end
  end

  task automatic push_item(logic [1:0] op, int mag);
    chan_item_t it;
    it.op = op;
    it.mag = mag[12:0];
    pending_items.push_back(it);
  endtask

  function automatic chan_item_t rand_item();
    chan_item_t it;
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 55) it.op = CMD_TICK;
    else if (sel < 75) it.op = CMD_SET_TARGET;
    else if (sel < 92) it.op = CMD_SET_NOW;
    else it.op = CMD_UNUSED;
    case ($urandom_range(9))
      0: v = int'($urandom_range(8191));
      1: v = ($urandom_range(1) == 0) ? -4096 : 4095;
      default: v = int'($urandom_range(2400)) - 1200;
    endcase
    it.mag = v[12:0];
    return it;
  endfunction

  task automatic set_reg(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    case (idx)
      REG_PULSE_MIN:      cfg_pmin = val & 'h7FFF;
      REG_PULSE_MAX:      cfg_pmax = val & 'h7FFF;
      REG_PULSE_CENTER:   cfg_center = val & 'h7FFF;
      REG_STEP_SIZE:      cfg_step = val & 'h3FF;
      REG_SNAP_THRESHOLD: cfg_snap = val & 'h1FFF;
      REG_TIMEOUT_TICKS:  cfg_timeout = val & 'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic shuffle_config(bit wild);
    int lo, hi;
    if (wild) begin
      lo = $urandom_range(20000);
      hi = $urandom_range(20000);
      set_reg(REG_PULSE_CENTER, $urandom_range(20000));
    end else begin
      lo = $urandom_range(1400, 800);
      hi = $urandom_range(2400, 1600);
      set_reg(REG_PULSE_CENTER, $urandom_range(hi, lo));
    end
    set_reg(REG_PULSE_MIN, lo);
    set_reg(REG_PULSE_MAX, hi);
    set_reg(REG_STEP_SIZE, $urandom_range(120));
    set_reg(REG_SNAP_THRESHOLD, $urandom_range(80));
    set_reg(REG_TIMEOUT_TICKS, $urandom_range(25));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pulses.size() != 0);
    repeat (5) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: begin
          set_reg(REG_PULSE_MIN, 0);
          set_reg(REG_PULSE_MAX, 20000);
          set_reg(REG_PULSE_CENTER, 0);
          set_reg(REG_STEP_SIZE, 0);
          set_reg(REG_SNAP_THRESHOLD, 0);
          set_reg(REG_TIMEOUT_TICKS, 0);
        end
        2: begin
          // min above max
          set_reg(REG_PULSE_MIN, 20000);
          set_reg(REG_PULSE_MAX, 0);
          set_reg(REG_PULSE_CENTER, 20000);
          set_reg(REG_STEP_SIZE, 1000);
          set_reg(REG_SNAP_THRESHOLD, 8191);
          set_reg(REG_TIMEOUT_TICKS, 65535);
        end
        default: shuffle_config(ph % 2 == 1);
      endcase
      @(posedge clk);
      tx_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 63 : 0;
      rx_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 13 : 0;
      if (ph == 0) begin
        push_item(CMD_TICK, 0);
        push_item(CMD_UNUSED, 4095);
        push_item(CMD_UNUSED, -4096);
        push_item(CMD_SET_TARGET, 4095);
        push_item(CMD_TICK, -4096);
        push_item(CMD_TICK, 4095);
        push_item(CMD_TICK, 0);
        push_item(CMD_SET_NOW, -4096);
        push_item(CMD_SET_NOW, 4095);
        push_item(CMD_SET_NOW, -1);
        push_item(CMD_SET_NOW, 1);
        push_item(CMD_SET_NOW, -1000);
        push_item(CMD_SET_NOW, 1000);
        push_item(CMD_SET_NOW, -1001);
        push_item(CMD_SET_TARGET, 1030);
        push_item(CMD_TICK, 0);
        push_item(CMD_TICK, 0);
        push_item(CMD_SET_TARGET, -4096);
        push_item(CMD_TICK, 0);
        push_item(CMD_TICK, 0);
        push_item(CMD_SET_TARGET, 0);
        push_item(CMD_TICK, 0);
      end
      repeat (ITEMS_PER_PHASE) pending_items.push_back(rand_item());
      if (ph == 4) begin
        while (pending_items.size() > 200) @(posedge clk);
        fork
          begin
            rx_hold = 1'b1;
            repeat (60) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
        while (pending_items.size() > 100) @(posedge clk);
        tx_hold = 1'b1;
        do @(negedge clk);
        while (in_valid || expected_pulses.size() != 0);
        @(posedge clk);
        tx_hold = 1'b0;
      end
      wait_idle();
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/slesc_pkg.sv
hw/rtl/slew_limited_esc_pulse_channel_unit.sv
dv/tb_top.sv
